@@ sv/art_pkg.sv @@
// ----------------------------------------------------------------------------
// Automaton reachability trim package
// Shared types, constants and helper functions of the trim unit.
// ----------------------------------------------------------------------------
package art_pkg;

    // Graph size and field widths.
    localparam int MAX_STATES = 32;
    localparam int ADDR_W     = 5;
    localparam int COUNT_W    = 6;
    localparam int ROW_W      = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_STATE_COUNT = 2'd0;
    localparam cfg_idx_t REG_INIT_STATE  = 2'd1;
    localparam cfg_idx_t REG_MARKED_MASK = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_EMIT
    } art_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_open;   // rows may be taken on the input channel
        logic start;       // initialize the closure sets and begin a sweep
        logic run;         // a sweep over the adjacency rows is in progress
        logic restart;     // begin another sweep
        logic emit_start;  // begin the result run
    } art_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_end;   // last row of the current sweep is being applied
        logic dirty;       // some set bit changed during the current sweep
        logic emit_done;   // last result word is taken
    } art_stat_t;

    // Number of states in use: zero acts as one, large counts are clipped.
    function automatic logic [COUNT_W-1:0] states_in_use(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] n;
        n = cnt;
        if (n == '0) begin
            n = COUNT_W'(1);
        end else if (n > COUNT_W'(MAX_STATES)) begin
            n = COUNT_W'(MAX_STATES);
        end
        return n;
    endfunction

    // Bit mask of the states in use.
    function automatic logic [ROW_W-1:0] use_mask(input logic [COUNT_W-1:0] n);
        return ~({ROW_W{1'b1}} << n);
    endfunction

endpackage

@@ sv/art_ctrl.sv @@
// ----------------------------------------------------------------------------
// Automaton reachability trim controller
// Sequences row loading, the fixed-point sweeps and the result run.
// ----------------------------------------------------------------------------
module art_ctrl
    import art_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    input  art_stat_t stat,
    output art_cmd_t  cmd
);

    art_state_t state_reg;
    art_state_t state_next;
    logic       last_fire;

    // The final row of a graph is accepted.
    assign last_fire = (state_reg == ST_LOAD) && s_tvalid && s_tlast;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (last_fire) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (stat.sweep_end && !stat.dirty) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.emit_done) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Commands.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.load_open = 1'b1;
                cmd.start     = last_fire;
            end
            ST_SWEEP: begin
                cmd.run        = 1'b1;
                cmd.restart    = stat.sweep_end && stat.dirty;
                cmd.emit_start = stat.sweep_end && !stat.dirty;
            end
            ST_EMIT: begin
                cmd = '0;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/art_dpath.sv @@
// ----------------------------------------------------------------------------
// Automaton reachability trim datapath
// Adjacency memory, configuration registers, accessible and coaccessible
// sets, sweep address pipeline and result register.
// ----------------------------------------------------------------------------
module art_dpath
    import art_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  art_cmd_t              cmd,
    output art_stat_t             stat,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [ROW_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [COUNT_W-1:0] state_count_reg;
    logic [ADDR_W-1:0]  init_state_reg;
    logic [ROW_W-1:0]   marked_mask_reg;

    // Adjacency memory and its registered read port.
    logic [ROW_W-1:0]   adj_mem [MAX_STATES];
    logic [ROW_W-1:0]   rdata_reg;

    // Sweep pipeline.
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic               rd_on_reg;
    logic               p_vld_reg;
    logic [ADDR_W-1:0]  p_idx_reg;

    // Closure sets.
    logic [ROW_W-1:0]   acc_reg;
    logic [ROW_W-1:0]   acc_next;
    logic [ROW_W-1:0]   coacc_reg;
    logic [ROW_W-1:0]   coacc_next;
    logic               dirty_reg;

    // Result register.
    logic               m_valid_reg;
    logic [ADDR_W-1:0]  e_idx_reg;

    logic [COUNT_W-1:0] n_use;
    logic [ADDR_W-1:0]  last_idx;
    logic [ROW_W-1:0]   mask;
    logic [ROW_W-1:0]   init_vec;
    logic [ROW_W-1:0]   row_m;
    logic               c_hit;
    logic               change;
    logic               in_fire;
    logic               m_fire;

    assign n_use    = states_in_use(state_count_reg);
    assign last_idx = ADDR_W'(n_use - COUNT_W'(1));
    assign mask     = use_mask(n_use);
    assign init_vec = ({1'b0, init_state_reg} < n_use) ? (ROW_W'(1) << init_state_reg) : '0;

    assign s_tready  = cmd.load_open;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg <= COUNT_W'(32);
            init_state_reg  <= '0;
            marked_mask_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STATE_COUNT: state_count_reg <= cfg_data[COUNT_W-1:0];
                REG_INIT_STATE:  init_state_reg  <= cfg_data[ADDR_W-1:0];
                REG_MARKED_MASK: marked_mask_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Adjacency rows are written on input words and read during sweeps.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            adj_mem[s_tdata[ADDR_W-1:0]] <= s_tdata[ADDR_W +: ROW_W];
        end
        rdata_reg <= adj_mem[rd_addr_reg];
    end

    // Read address sequencing: one row per cycle from state 0 to the last in use.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_on_reg   <= 1'b0;
            rd_addr_reg <= '0;
            p_vld_reg   <= 1'b0;
            p_idx_reg   <= '0;
        end else begin
            p_vld_reg <= rd_on_reg && cmd.run;
            p_idx_reg <= rd_addr_reg;
            if (cmd.start || cmd.restart) begin
                rd_on_reg   <= 1'b1;
                rd_addr_reg <= '0;
            end else if (cmd.run && rd_on_reg) begin
                if (rd_addr_reg == last_idx) begin
                    rd_on_reg <= 1'b0;
                end else begin
                    rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                end
            end
        end
    end

    // Apply one row: grow the forward set and test the row for coaccessibility.
    always_comb begin
        row_m    = rdata_reg & mask;
        acc_next = acc_reg[p_idx_reg] ? (acc_reg | row_m) : acc_reg;
        c_hit    = |(row_m & ((marked_mask_reg & mask) | coacc_reg));
        coacc_next = coacc_reg | (ROW_W'(c_hit) << p_idx_reg);
        change   = p_vld_reg && ((acc_next != acc_reg) || (coacc_next != coacc_reg));
    end

    assign stat.sweep_end = p_vld_reg && (p_idx_reg == last_idx);
    assign stat.dirty     = dirty_reg || change;

    // Closure set registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= 1'b0;
        end else if (cmd.start) begin
            dirty_reg <= 1'b0;
        end else if (p_vld_reg) begin
            dirty_reg <= stat.sweep_end ? 1'b0 : (dirty_reg || change);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg   <= init_vec;
            coacc_reg <= '0;
        end else if (p_vld_reg) begin
            acc_reg   <= acc_next;
            coacc_reg <= coacc_next;
        end
    end

    // Result register: one word per state in use.
    assign m_fire = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            e_idx_reg   <= '0;
        end else if (cmd.emit_start) begin
            m_valid_reg <= 1'b1;
            e_idx_reg   <= '0;
        end else if (m_fire) begin
            if (e_idx_reg == last_idx) begin
                m_valid_reg <= 1'b0;
            end else begin
                e_idx_reg <= e_idx_reg + ADDR_W'(1);
            end
        end
    end

    assign stat.emit_done = m_fire && (e_idx_reg == last_idx);

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = (e_idx_reg == last_idx);
    assign m_tdata  = {1'b0, coacc_reg[e_idx_reg], acc_reg[e_idx_reg], e_idx_reg};

endmodule

@@ sv/automaton_reachability_trim_unit.sv @@
// ----------------------------------------------------------------------------
// Automaton reachability trim unit
// Loads a transition graph row by row and reports, per state in use,
// whether it is accessible and coaccessible.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one adjacency row per word: the source state and
//   a 32-bit successor mask. Rows load one per cycle. The word with s_tlast
//   high is stored like the others and then starts the closure; s_tready
//   stays low until the results for that graph are all delivered.
//   The closure runs repeated sweeps over the rows in use, one row read from
//   the adjacency memory per cycle; sweeps repeat until one changes nothing,
//   at most n + 1 of them for n states in use. The result stream then gives
//   n words, one per cycle while m_tready is high, in order from state 0,
//   with m_tlast on the last one.
//   A stalled receiver simply holds the current result word in place.
//   Configuration writes are taken at any time, one per cycle, and are meant
//   for idle periods only. Reset restores a count of 32 states, initial
//   state 0 and no marked states; the adjacency rows hold nothing defined
//   until they are loaded.
// ----------------------------------------------------------------------------
module automaton_reachability_trim_unit
    import art_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: row_index [4:0], successor_bits [36:5], zero fill [39:37]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    // m_tdata: state_index [4:0], accessible [5], coaccessible [6], zero fill [7]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [ROW_W-1:0]      cfg_data
);

    art_cmd_t  cmd;
    art_stat_t stat;

    // Controller.
    art_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    art_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

`ifndef SYNTHESIS
    // Rows are never taken while results are pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input open while results pending");

    // The final row closes the input side.
    a_last_row_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after final row");

    // The last result ends the result run.
    a_last_result_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result valid after last result");
`endif

endmodule

@@ tb/automaton_reachability_trim_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Automaton reachability trim unit testbench
// Streams adjacency rows into the trim unit and checks every result word
// against a predictor that keeps its own copy of the loaded graph. A short
// directed table covers a count of zero, self loops, marked states reached
// only through a cycle, an initial state out of use and ignored rows. A
// random part follows with well-formed graph loads, stray rows and early
// closures. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module automaton_reachability_trim_unit_tb;
    import art_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 100;
    localparam int RANDOM_ITEMS  = 325;
    localparam int HOLD_CYCLES   = 400;

    // Expected result word for one state.
    typedef struct packed {
        logic [4:0] idx;
        logic       acc;
        logic       coacc;
        logic       last;
    } trim_result_t;

    // One line of the directed table: a register write or a row word.
    typedef enum logic {
        STEP_CFG,
        STEP_ROW
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        cfg_idx_t    reg_idx;
        logic [4:0]  row;
        logic [31:0] value;
        logic        last;
        logic        typed;
        logic [31:0] acc;
        logic [31:0] coacc;
    } directed_step_t;

    localparam int DIRECTED_LEN = 26;
    localparam directed_step_t DIRECTED_STEPS [DIRECTED_LEN] = '{
        // One state in use: a self loop, no marks.
        '{STEP_CFG, REG_STATE_COUNT, 5'd0,  32'd1,         1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h1, 32'h0},
        // Everything marked: a self loop makes state 0 coaccessible.
        '{STEP_CFG, REG_MARKED_MASK, 5'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd0,  32'h0000_0001, 1'b1, 1'b1, 32'h1, 32'h1},
        // Marked but without a cycle, and successors out of use.
        '{STEP_ROW, REG_STATE_COUNT, 5'd0,  32'hFFFF_FFFE, 1'b1, 1'b1, 32'h1, 32'h0},
        // A count of zero acts as one.
        '{STEP_CFG, REG_STATE_COUNT, 5'd0,  32'd0,         1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h1, 32'h0},
        // Two states in a loop, starting from state 1.
        '{STEP_CFG, REG_STATE_COUNT, 5'd0,  32'd2,         1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_CFG, REG_INIT_STATE,  5'd0,  32'd1,         1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd1,  32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd0,  32'h0000_0002, 1'b1, 1'b1, 32'h3, 32'h3},
        // Initial state out of use: nothing is accessible.
        '{STEP_CFG, REG_INIT_STATE,  5'd0,  32'd5,         1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 32'h2},
        // Four-state chain; row 31 and the high successor bits are ignored.
        '{STEP_CFG, REG_STATE_COUNT, 5'd0,  32'd4,         1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_CFG, REG_INIT_STATE,  5'd0,  32'd0,         1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_CFG, REG_MARKED_MASK, 5'd0,  32'h0000_0008, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd3,  32'hFFFF_FFF0, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd2,  32'h0000_0008, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd1,  32'h0000_0004, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd0,  32'h0000_0002, 1'b1, 1'b1, 32'hF, 32'h7},
        // Close the chain into a loop and mark state 0.
        '{STEP_CFG, REG_MARKED_MASK, 5'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd3,  32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd2,  32'h0000_0005, 1'b1, 1'b0, 32'h0, 32'h0},
        // Highest initial state index, out of use.
        '{STEP_CFG, REG_INIT_STATE,  5'd0,  32'd31,        1'b0, 1'b0, 32'h0, 32'h0},
        '{STEP_ROW, REG_STATE_COUNT, 5'd1,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = REG_STATE_COUNT;
    logic [ROW_W-1:0]      cfg_data  = '0;

    // Predictor copy of the graph and of the registers.
    logic [31:0]  adj_rows [32];
    logic [31:0]  rows_loaded = '0;
    logic [5:0]   cur_count   = 6'd32;
    logic [4:0]   cur_init    = 5'd0;
    logic [31:0]  cur_marked  = '0;
    trim_result_t pending_trim_results [$];

    int fault_count = 0;
    int items_sent  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_req    = 0;
    int hold_left   = 0;

    automaton_reachability_trim_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Number of states the closure covers under the current count.
    function automatic int active_states();
        int c;
        c = int'(cur_count);
        if (c == 0) c = 1;
        if (c > 32) c = 32;
        return c;
    endfunction

    function automatic logic [31:0] active_mask(int n);
        return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    endfunction

    // Closure over the rows in use, then one expected word per state.
    // Typed rows of the directed table supply their own flag masks.
    function automatic void queue_trim_results(logic typed, logic [31:0] t_acc,
                                               logic [31:0] t_coacc);
        int           n;
        logic [31:0]  m;
        logic [31:0]  reach [32];
        logic [31:0]  grown;
        logic [31:0]  acc_set;
        bit           changed;
        trim_result_t r;
        n = active_states();
        m = active_mask(n);
        for (int i = 0; i < n; i++) reach[i] = adj_rows[i] & m;
        do begin
            changed = 1'b0;
            for (int i = 0; i < n; i++) begin
                grown = reach[i];
                for (int j = 0; j < n; j++)
                    if (reach[i][j]) grown |= adj_rows[j] & m;
                if (grown != reach[i]) begin
                    reach[i] = grown;
                    changed  = 1'b1;
                end
            end
        end while (changed);
        acc_set = '0;
        if (int'(cur_init) < n) acc_set = ((32'd1 << cur_init) | reach[cur_init]) & m;
        for (int i = 0; i < n; i++) begin
            r.idx   = i[4:0];
            r.acc   = typed ? t_acc[i] : acc_set[i];
            r.coacc = typed ? t_coacc[i] : |(reach[i] & cur_marked & m);
            r.last  = (i == n - 1);
            pending_trim_results.push_back(r);
        end
    endfunction

    // Idle and stall percentages of one traffic phase.
    function automatic void set_traffic(int phase);
        case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 25; stall_pct = 25; end
        endcase
    endfunction

    // Offer one row word, with random gaps ahead of it, until it is taken.
    task automatic send_row(logic [4:0] row, logic [31:0] bits, logic last,
                            logic typed = 1'b0, logic [31:0] t_acc = '0,
                            logic [31:0] t_coacc = '0);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, bits, row};
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        adj_rows[row]    = bits;
        rows_loaded[row] = 1'b1;
        items_sent++;
        if (last) queue_trim_results(typed, t_acc, t_coacc);
    endtask

    task automatic sender_stop();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_trim_results.size() != 0) @(posedge aclk);
    endtask

    // Register writes only with the block idle and every result delivered.
    task automatic cfg_write(cfg_idx_t idx, logic [31:0] value);
        sender_stop();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_STATE_COUNT: cur_count  = value[5:0];
            REG_INIT_STATE:  cur_init   = value[4:0];
            REG_MARKED_MASK: cur_marked = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Successor mask of random shape: empty, full, single, chain, sparse, random.
    function automatic logic [31:0] row_bits(int row, int n);
        case ($urandom_range(7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1 << $urandom_range(n - 1);
            3: return 32'd1 << ((row + 1) % n);
            4: return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // New settings; a count is mostly small, now and then clipped or full.
    task automatic reconfigure(bit all_regs);
        logic [31:0] count;
        case ($urandom_range(19))
            14, 15: count = $urandom_range(31, 9);
            16:     count = 32;
            17:     count = 0;
            18:     count = $urandom_range(63, 33);
            19:     count = 63;
            default: count = $urandom_range(8, 1);
        endcase
        if (all_regs || $urandom_range(1)) cfg_write(REG_STATE_COUNT, count);
        if (all_regs || $urandom_range(1)) begin
            if ($urandom_range(99) < 75)
                cfg_write(REG_INIT_STATE, $urandom_range(active_states() - 1));
            else
                cfg_write(REG_INIT_STATE, $urandom_range(31));
        end
        if (all_regs || $urandom_range(1)) begin
            case ($urandom_range(3))
                0: cfg_write(REG_MARKED_MASK, 32'h0);
                1: cfg_write(REG_MARKED_MASK, 32'hFFFF_FFFF);
                2: cfg_write(REG_MARKED_MASK, $urandom);
                default: cfg_write(REG_MARKED_MASK, $urandom & $urandom);
            endcase
        end
    endtask

    // One graph: every row in use in shuffled order with stray rows between,
    // or, once all rows in use hold data, a partial load closed early.
    task automatic run_graph();
        int          n;
        int          order [32];
        int          pick;
        int          swap;
        int          cut;
        logic [31:0] need;
        n    = active_states();
        need = active_mask(n);
        for (int k = 0; k < n; k++) order[k] = k;
        for (int k = n - 1; k > 0; k--) begin
            pick        = $urandom_range(k);
            swap        = order[k];
            order[k]    = order[pick];
            order[pick] = swap;
        end
        if (((rows_loaded & need) == need) && $urandom_range(99) < 15) begin
            cut = $urandom_range(n - 1);
            for (int k = 0; k < cut; k++)
                send_row(order[k][4:0], row_bits(order[k], n), 1'b0);
            pick = $urandom_range(31);
            send_row(pick[4:0], row_bits(pick, n), 1'b1);
        end else begin
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(99) < 10) begin
                    pick = (n < 32 && $urandom_range(1)) ? $urandom_range(31, n)
                                                         : $urandom_range(31);
                    send_row(pick[4:0], row_bits(pick, n), 1'b0);
                end
                send_row(order[k][4:0], row_bits(order[k], n), k == n - 1);
            end
        end
    endtask

    // Receiver: a requested hold-off first, otherwise random stalls.
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each delivered word with the oldest expectation.
    always @(posedge aclk) begin
        trim_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_trim_results.size() == 0) begin
                $error("unexpected result word: state_index %0d", m_tdata[4:0]);
                fault_count++;
            end else begin
                want = pending_trim_results.pop_front();
                if (m_tdata[4:0] != want.idx) begin
                    $error("state_index mismatch: expected %0d, actual %0d",
                           want.idx, m_tdata[4:0]);
                    fault_count++;
                end
                if (m_tdata[5] != want.acc) begin
                    $error("accessible mismatch: expected %0d, actual %0d",
                           want.acc, m_tdata[5]);
                    fault_count++;
                end
                if (m_tdata[6] != want.coacc) begin
                    $error("coaccessible mismatch: expected %0d, actual %0d",
                           want.coacc, m_tdata[6]);
                    fault_count++;
                end
                if (m_tlast != want.last) begin
                    $error("last_result mismatch: expected %0d, actual %0d",
                           want.last, m_tlast);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("automaton_reachability_trim_unit verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, back-pressure, random graphs.
    initial begin
        directed_step_t step;
        int             graph_no;
        int             start_items;
        graph_no = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_traffic(3);
        for (int k = 0; k < DIRECTED_LEN; k++) begin
            step = DIRECTED_STEPS[k];
            if (step.kind == STEP_CFG)
                cfg_write(step.reg_idx, step.value);
            else
                send_row(step.row, step.value, step.last, step.typed, step.acc, step.coacc);
        end

        // Long receiver hold-off while two graphs are pushed back to back,
        // then the sender waits for every result.
        cfg_write(REG_STATE_COUNT, 32'd8);
        set_traffic(0);
        @(posedge aclk);
        hold_req = HOLD_CYCLES;
        run_graph();
        run_graph();
        sender_stop();
        wait_drained();

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            set_traffic(graph_no);
            if (graph_no == 0 || $urandom_range(99) < 40) reconfigure(graph_no == 0);
            run_graph();
            graph_no++;
        end

        sender_stop();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("automaton_reachability_trim_unit verification clean");
        else
            $display("automaton_reachability_trim_unit verification failed");
        $finish;
    end

endmodule

@@ automaton_reachability_trim_unit.f @@
sv/art_pkg.sv
sv/art_ctrl.sv
sv/art_dpath.sv
sv/automaton_reachability_trim_unit.sv
tb/automaton_reachability_trim_unit_tb.sv
